/* rtl/core/srs_pkg.sv */
`timescale 1ns / 1ps

package srs_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned FILL_W = 8;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] return_address;
        logic [WORD_W-1:0] frame_location;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] return_address;
        logic [WORD_W-1:0] frame_location;
    } entry_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
        logic [WORD_W-1:0] saved_handle;
        logic [WORD_W-1:0] saved_address;
    } res_t;

endpackage

/* rtl/core/srs_entry_ram.sv */
`timescale 1ns / 1ps

module srs_entry_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7
) (
    input  logic                  aclk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output srs_pkg::entry_t       rd_data,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  srs_pkg::entry_t       wr_data
);

    srs_pkg::entry_t entry_mem [DEPTH];
    srs_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/srs_cmp.sv */
`timescale 1ns / 1ps

module srs_cmp (
    input  logic                       is_pop,
    input  logic [srs_pkg::WORD_W-1:0] entry_loc,
    input  logic [srs_pkg::WORD_W-1:0] key_loc,
    output logic                       hit
);

    // pop matches on equality; push discards entries at or below the key
    always_comb begin
        if (is_pop) begin
            hit = (entry_loc == key_loc);
        end else begin
            hit = (entry_loc <= key_loc);
        end
    end

endmodule

/* rtl/core/srs_seq.sv */
`timescale 1ns / 1ps

module srs_seq #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned CW    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  srs_pkg::req_t         in_req,
    input  logic                  out_free,
    output logic                  res_valid,
    output srs_pkg::res_t         res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_END   = 2'd3;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [1:0]                 state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              ptr_reg, ptr_next;
    logic                       found_reg, found_next;
    srs_pkg::req_t              req_reg, req_next;
    logic [srs_pkg::WORD_W-1:0] sav_ra_reg, sav_ra_next;
    logic [srs_pkg::WORD_W-1:0] sav_h_reg, sav_h_next;

    logic [CW-1:0]   ptr_dec;
    logic            rd_en;
    logic            wr_en;
    srs_pkg::entry_t rd_data;
    srs_pkg::entry_t wr_data;
    logic            hit;

    assign ptr_dec = ptr_reg - CW'(1);
    assign wr_data = '{handle: req_reg.handle,
                       return_address: req_reg.return_address,
                       frame_location: req_reg.frame_location};

    srs_entry_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (ptr_dec[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg[AW-1:0]),
        .wr_data (wr_data)
    );

    srs_cmp u_cmp (
        .is_pop    (req_reg.cmd == srs_pkg::CMD_POP),
        .entry_loc (rd_data.frame_location),
        .key_loc   (req_reg.frame_location),
        .hit       (hit)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        found_next  = found_reg;
        req_next    = req_reg;
        sav_ra_next = sav_ra_reg;
        sav_h_next  = sav_h_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    req_next   = in_req;
                    ptr_next   = cnt_reg;
                    found_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (ptr_reg == '0) begin
                    state_next = S_END;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (req_reg.cmd == srs_pkg::CMD_POP) begin
                    ptr_next = ptr_dec;
                    if (hit) begin
                        found_next  = 1'b1;
                        sav_ra_next = rd_data.return_address;
                        sav_h_next  = rd_data.handle;
                        state_next  = S_END;
                    end else begin
                        state_next = S_READ;
                    end
                end else begin
                    if (hit) begin
                        ptr_next   = ptr_dec;
                        state_next = S_READ;
                    end else begin
                        state_next = S_END;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                    if (req_reg.cmd == srs_pkg::CMD_PUSH) begin
                        if (ptr_reg == DEPTH_C) begin
                            cnt_next   = ptr_reg;
                            res.status = srs_pkg::ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            cnt_next   = ptr_reg + CW'(1);
                            res.status = srs_pkg::ST_OK;
                        end
                    end else if (found_reg) begin
                        cnt_next          = ptr_reg;
                        res.status        = srs_pkg::ST_OK;
                        res.saved_address = sav_ra_reg;
                        res.saved_handle  = sav_h_reg;
                    end else begin
                        res.status = srs_pkg::ST_NOT_FOUND;
                    end
                    res.fill = srs_pkg::FILL_W'(cnt_next);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        ptr_reg    <= ptr_next;
        found_reg  <= found_next;
        req_reg    <= req_next;
        sav_ra_reg <= sav_ra_next;
        sav_h_reg  <= sav_h_next;
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_READ))
        else $error("request accepted without starting scan");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && req_reg.cmd == srs_pkg::CMD_POP && found_reg)
        |=> (cnt_reg < $past(cnt_reg)))
        else $error("matched pop did not shrink stack");

    a_pop_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && req_reg.cmd == srs_pkg::CMD_POP && !found_reg)
        |=> $stable(cnt_reg))
        else $error("unmatched pop changed stack");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (ptr_reg < DEPTH_C && state_reg == S_END))
        else $error("entry write outside stack");

endmodule

/* rtl/core/shadow_return_address_stack_top.sv */
`timescale 1ns / 1ps

// Shadow return address stack.
// Input channel s_*: one request per handshake. s_tuser is the command (push or
// pop); s_tdata carries frame location, return address and handle.
// Result channel m_*: one result per request, in order. m_tuser is the status
// (ok, full, not found); m_tdata carries saved address, saved handle, fill.
// Scan: a request visits the top entries one at a time through a single
// entry memory read port and one shared compare unit; each visited entry passes
// through a read state and a compare state. The entries inspected are, for a
// push, the discarded entries plus one stopper and, for a pop, the entries down
// to and including the match; a scan that runs past the bottom entry passes
// through the read state once more before it ends. s_tready is high only while
// idle, so the next request is not accepted before the sequencer has handed on
// the result of the last.
// The result sits in an output register; a new request is accepted while it
// waits, and the sequencer holds its finished result until m_tready frees the
// register.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// result; entry memory contents are not cleared.
module shadow_return_address_stack_top #(
    parameter int unsigned STACK_DEPTH = 128
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // frame_location, return_address, handle
    input  logic          s_tuser,   // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // saved_address, saved_handle, fill
    output logic [1:0]    m_tuser    // status
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    srs_pkg::req_t in_req;
    srs_pkg::res_t res;
    srs_pkg::res_t out_reg;
    logic          res_valid;
    logic          out_valid_reg;
    logic          out_free;

    assign in_req = '{cmd: s_tuser,
                      handle: s_tdata[191:128],
                      return_address: s_tdata[127:64],
                      frame_location: s_tdata[63:0]};

    assign out_free = !out_valid_reg || m_tready;

    srs_seq #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.fill, out_reg.saved_handle, out_reg.saved_address};

endmodule
